### sv/cvh_pkg.sv
// Shared constants and helpers for the monotone chain convex hull core.
package cvh_pkg;

  // Store sizing and coordinate width
  localparam int unsigned MAX_POINTS = 32;
  localparam int unsigned COORD_BITS = 16;

  // Derived widths
  localparam int unsigned IDX_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int unsigned STK_DEPTH = 2 * MAX_POINTS;
  localparam int unsigned STK_AW    = $clog2(STK_DEPTH);
  localparam int unsigned DEP_W     = $clog2(STK_DEPTH + 1);
  localparam int unsigned PT_W      = 2 * COORD_BITS;
  localparam int unsigned DIFF_W    = COORD_BITS + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [PT_W-1:0]              point_t;

  // Pack x above y in one store word
  function automatic point_t pack_point(coord_t x, coord_t y);
    return {x, y};
  endfunction

  function automatic coord_t point_x(point_t p);
    return coord_t'(p[PT_W-1:COORD_BITS]);
  endfunction

  function automatic coord_t point_y(point_t p);
    return coord_t'(p[COORD_BITS-1:0]);
  endfunction

  // Order by x, then by y: true when a sorts after b
  function automatic logic point_after(point_t a, point_t b);
    return (point_x(a) > point_x(b)) ||
           ((point_x(a) == point_x(b)) && (point_y(a) > point_y(b)));
  endfunction

endpackage

### sv/cvh_point_if.sv
// Input channel carrying one point per transaction.
interface cvh_point_if;
  logic                  valid;
  logic                  ready;
  cvh_pkg::coord_t       point_x;
  logic [cvh_pkg::COORD_BITS-1:0] point_y;
  logic                  final_point;

  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

### sv/cvh_hull_if.sv
// Output channel carrying one hull point per transaction.
interface cvh_hull_if;
  logic                  valid;
  logic                  ready;
  cvh_pkg::coord_t       hull_x;
  logic [cvh_pkg::COORD_BITS-1:0] hull_y;
  logic                  hull_last;

  modport source (output valid, hull_x, hull_y, hull_last, input ready);
  modport sink   (input valid, hull_x, hull_y, hull_last, output ready);
endinterface

### sv/cvh_ram.sv
// Generic one-write, one-read RAM with registered read data.
module cvh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### sv/convex_hull_monotone_chain_core.sv
// Convex hull core: load, insertion sort in RAM, two stack scans, emit.
// Loading takes one cycle per point; the sort moves elements by RAM read and
// compare-and-write, each cross product test reads two stack entries and their
// points, multiplies and compares, and each hull point waits on output stalls.
// All of it is bound by the single read port of the point RAM.
// Reset clears the control state; RAM contents are not cleared.
module convex_hull_monotone_chain_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  cvh_point_if.sink    point_i,
  cvh_hull_if.source   hull_o
);

  localparam int unsigned ST_W = 5;
  localparam logic [ST_W-1:0] S_LOAD = 5'd0;
  localparam logic [ST_W-1:0] S_SI   = 5'd1;
  localparam logic [ST_W-1:0] S_SK   = 5'd2;
  localparam logic [ST_W-1:0] S_SR   = 5'd3;
  localparam logic [ST_W-1:0] S_SC   = 5'd4;
  localparam logic [ST_W-1:0] S_PC   = 5'd5;
  localparam logic [ST_W-1:0] S_PCW  = 5'd6;
  localparam logic [ST_W-1:0] S_CHK  = 5'd7;
  localparam logic [ST_W-1:0] S_A1   = 5'd8;
  localparam logic [ST_W-1:0] S_A2   = 5'd9;
  localparam logic [ST_W-1:0] S_A3   = 5'd10;
  localparam logic [ST_W-1:0] S_A4   = 5'd11;
  localparam logic [ST_W-1:0] S_MUL  = 5'd12;
  localparam logic [ST_W-1:0] S_CMP  = 5'd13;
  localparam logic [ST_W-1:0] S_PUSH = 5'd14;
  localparam logic [ST_W-1:0] S_EK   = 5'd15;
  localparam logic [ST_W-1:0] S_EI   = 5'd16;
  localparam logic [ST_W-1:0] S_EP   = 5'd17;
  localparam logic [ST_W-1:0] S_EW   = 5'd18;

  localparam logic [cvh_pkg::CNT_W-1:0] CNT_ONE = cvh_pkg::CNT_W'(1);
  localparam logic [cvh_pkg::DEP_W-1:0] DEP_ONE = cvh_pkg::DEP_W'(1);
  localparam logic [cvh_pkg::DEP_W-1:0] DEP_TWO = cvh_pkg::DEP_W'(2);
  localparam logic [cvh_pkg::CNT_W-1:0] CNT_MAX = cvh_pkg::CNT_W'(cvh_pkg::MAX_POINTS);

  logic [ST_W-1:0]                   state_q, state_d;
  logic [cvh_pkg::CNT_W-1:0]         count_q, count_d;
  logic [cvh_pkg::CNT_W-1:0]         i_q, i_d;
  logic [cvh_pkg::CNT_W-1:0]         j_q, j_d;
  logic [cvh_pkg::IDX_W-1:0]         c_q, c_d;
  logic                              pass_q, pass_d;
  logic [cvh_pkg::DEP_W-1:0]         depth_q, depth_d;
  logic [cvh_pkg::DEP_W-1:0]         first_q, first_d;
  logic [cvh_pkg::DEP_W-1:0]         k_q, k_d;
  cvh_pkg::point_t                   key_q, key_d;
  cvh_pkg::point_t                   a_q, a_d, b_q, b_d, cp_q, cp_d;
  logic [cvh_pkg::IDX_W-1:0]         bi_q, bi_d;
  logic signed [cvh_pkg::PROD_W-1:0] p1_q, p1_d, p2_q, p2_d;
  cvh_pkg::point_t                   out_q, out_d;
  logic                              last_q, last_d;

  // RAM ports
  logic                        pt_we;
  logic [cvh_pkg::IDX_W-1:0]   pt_waddr, pt_raddr;
  cvh_pkg::point_t             pt_wdata, pt_rdata;
  logic                        stk_we;
  logic [cvh_pkg::STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [cvh_pkg::IDX_W-1:0]   stk_wdata, stk_rdata;

  cvh_ram #(.WIDTH(cvh_pkg::PT_W), .DEPTH(cvh_pkg::MAX_POINTS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  cvh_ram #(.WIDTH(cvh_pkg::IDX_W), .DEPTH(cvh_pkg::STK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  logic                              in_acc;
  logic [cvh_pkg::CNT_W-1:0]         jm1;
  logic [cvh_pkg::DEP_W:0]           base_p2;
  logic [cvh_pkg::DEP_W-1:0]         last_k;
  logic                              skip_k;
  logic signed [cvh_pkg::DIFF_W-1:0] abx, aby, acx, acy;

  assign in_acc  = point_i.valid && point_i.ready;
  assign jm1     = j_q - CNT_ONE;
  assign base_p2 = (pass_q ? {1'b0, first_q} : '0) + (cvh_pkg::DEP_W + 1)'(2);
  // Last emitted slot: top of second chain minus one, or end of the first
  assign last_k  = (depth_q >= first_q + cvh_pkg::DEP_W'(3)) ? depth_q - DEP_TWO
                                                             : first_q - DEP_ONE;
  assign skip_k  = (k_q >= first_q) && ((k_q == first_q) || (k_q + DEP_ONE == depth_q));

  // Cross product operands
  assign abx = cvh_pkg::DIFF_W'(cvh_pkg::point_x(b_q))  - cvh_pkg::DIFF_W'(cvh_pkg::point_x(a_q));
  assign aby = cvh_pkg::DIFF_W'(cvh_pkg::point_y(b_q))  - cvh_pkg::DIFF_W'(cvh_pkg::point_y(a_q));
  assign acx = cvh_pkg::DIFF_W'(cvh_pkg::point_x(cp_q)) - cvh_pkg::DIFF_W'(cvh_pkg::point_x(a_q));
  assign acy = cvh_pkg::DIFF_W'(cvh_pkg::point_y(cp_q)) - cvh_pkg::DIFF_W'(cvh_pkg::point_y(a_q));

  // Sequencer
  always_comb begin
    state_d = state_q;  count_d = count_q;  i_d = i_q;  j_d = j_q;
    c_d = c_q;  pass_d = pass_q;  depth_d = depth_q;  first_d = first_q;
    k_d = k_q;  key_d = key_q;  a_d = a_q;  b_d = b_q;  cp_d = cp_q;
    bi_d = bi_q;  p1_d = p1_q;  p2_d = p2_q;  out_d = out_q;  last_d = last_q;
    pt_we = 1'b0;  pt_waddr = '0;  pt_wdata = '0;  pt_raddr = '0;
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (count_q < CNT_MAX) begin
            pt_we    = 1'b1;
            pt_waddr = count_q[cvh_pkg::IDX_W-1:0];
            pt_wdata = cvh_pkg::pack_point(point_i.point_x,
                                           cvh_pkg::coord_t'(point_i.point_y));
            count_d  = count_q + CNT_ONE;
          end
          if (point_i.final_point) begin
            i_d     = CNT_ONE;
            state_d = S_SI;
          end
        end
      end
      S_SI: begin
        if (i_q >= count_q) begin
          c_d     = '0;
          pass_d  = 1'b0;
          depth_d = '0;
          state_d = S_PC;
        end else begin
          pt_raddr = i_q[cvh_pkg::IDX_W-1:0];
          state_d  = S_SK;
        end
      end
      S_SK: begin
        key_d   = pt_rdata;
        j_d     = i_q;
        state_d = S_SR;
      end
      S_SR: begin
        if (j_q == '0) begin
          pt_we    = 1'b1;
          pt_waddr = j_q[cvh_pkg::IDX_W-1:0];
          pt_wdata = key_q;
          i_d      = i_q + CNT_ONE;
          state_d  = S_SI;
        end else begin
          pt_raddr = jm1[cvh_pkg::IDX_W-1:0];
          state_d  = S_SC;
        end
      end
      S_SC: begin
        pt_we    = 1'b1;
        pt_waddr = j_q[cvh_pkg::IDX_W-1:0];
        if (cvh_pkg::point_after(pt_rdata, key_q)) begin
          pt_wdata = pt_rdata;
          j_d      = jm1;
          state_d  = S_SR;
        end else begin
          pt_wdata = key_q;
          i_d      = i_q + CNT_ONE;
          state_d  = S_SI;
        end
      end
      S_PC: begin
        pt_raddr = c_q;
        state_d  = S_PCW;
      end
      S_PCW: begin
        cp_d    = pt_rdata;
        state_d = S_CHK;
      end
      S_CHK: begin
        if ({1'b0, depth_q} >= base_p2) begin
          stk_raddr = cvh_pkg::STK_AW'(depth_q - DEP_TWO);
          state_d   = S_A1;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_A1: begin
        pt_raddr  = stk_rdata;
        stk_raddr = cvh_pkg::STK_AW'(depth_q - DEP_ONE);
        state_d   = S_A2;
      end
      S_A2: begin
        a_d     = pt_rdata;
        bi_d    = stk_rdata;
        state_d = S_A3;
      end
      S_A3: begin
        pt_raddr = bi_q;
        state_d  = S_A4;
      end
      S_A4: begin
        b_d     = pt_rdata;
        state_d = S_MUL;
      end
      S_MUL: begin
        p1_d    = cvh_pkg::PROD_W'(abx) * cvh_pkg::PROD_W'(acy);
        p2_d    = cvh_pkg::PROD_W'(aby) * cvh_pkg::PROD_W'(acx);
        state_d = S_CMP;
      end
      S_CMP: begin
        // Pop on a strict right turn
        if (p1_q < p2_q) begin
          depth_d = depth_q - DEP_ONE;
          state_d = S_CHK;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        stk_we    = 1'b1;
        stk_waddr = depth_q[cvh_pkg::STK_AW-1:0];
        stk_wdata = c_q;
        depth_d   = depth_q + DEP_ONE;
        state_d   = S_PC;
        if (!pass_q) begin
          if ({1'b0, c_q} == count_q - CNT_ONE) begin
            first_d = depth_q + DEP_ONE;
            pass_d  = 1'b1;
          end else begin
            c_d = c_q + cvh_pkg::IDX_W'(1);
          end
        end else if (c_q == '0) begin
          k_d     = '0;
          state_d = S_EK;
        end else begin
          c_d = c_q - cvh_pkg::IDX_W'(1);
        end
      end
      S_EK: begin
        if (k_q >= depth_q) begin
          count_d = '0;
          depth_d = '0;
          state_d = S_LOAD;
        end else if (skip_k) begin
          k_d = k_q + DEP_ONE;
        end else begin
          stk_raddr = k_q[cvh_pkg::STK_AW-1:0];
          state_d   = S_EI;
        end
      end
      S_EI: begin
        pt_raddr = stk_rdata;
        state_d  = S_EP;
      end
      S_EP: begin
        out_d   = pt_rdata;
        last_d  = (k_q == last_k);
        state_d = S_EW;
      end
      S_EW: begin
        if (hull_o.ready) begin
          k_d     = k_q + DEP_ONE;
          state_d = S_EK;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      depth_q <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      depth_q <= depth_d;
      pass_q  <= pass_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    i_q <= i_d;  j_q <= j_d;  c_q <= c_d;  first_q <= first_d;  k_q <= k_d;
    key_q <= key_d;  a_q <= a_d;  b_q <= b_d;  cp_q <= cp_d;  bi_q <= bi_d;
    p1_q <= p1_d;  p2_q <= p2_d;  out_q <= out_d;  last_q <= last_d;
  end

  // Channel outputs
  assign point_i.ready    = (state_q == S_LOAD);
  assign hull_o.valid     = (state_q == S_EW);
  assign hull_o.hull_x    = cvh_pkg::point_x(out_q);
  assign hull_o.hull_y    = cvh_pkg::point_y(out_q);
  assign hull_o.hull_last = last_q;

  // Never accept a point while a hull transaction is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(point_i.ready && hull_o.valid))
    else $error("input accepted during hull output");

  // The point count never exceeds the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("point count overflow");

  // A push never runs past the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> (depth_q < cvh_pkg::DEP_W'(cvh_pkg::STK_DEPTH)))
    else $error("chain stack overflow");

  // A final point always starts the sort
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && point_i.final_point) |=> (state_q == S_SI))
    else $error("final point did not start hull run");

endmodule
